// ===== design/pps_pkg.sv =====
// Package for the preemptive priority scheduler.
// Holds field widths, stream packing, the task record type and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

    // Default size of the task table
    localparam int NUM_SLOTS_DEF = 16;

    // Field widths of one input beat and one result beat
    localparam int SLOT_FIELD_W  = 4;
    localparam int BURST_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int TIME_W        = 32;

    // Stream widths
    localparam int S_TDATA_W     = 32;
    localparam int S_TUSER_W     = 1;
    localparam int M_TDATA_W     = 72;
    localparam int M_TUSER_W     = 3;

    // Input tuser code
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_ARRIVE   = 1'b1;

    // One entry of the task table
    typedef struct packed {
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  priority_val;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
    } task_rec_t;

    localparam int REC_W = $bits(task_rec_t);

    // Per-tick sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_FINISH
    } sched_state_t;

endpackage

// ===== design/pps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler: usage
// One input beat is one processor tick. s_tuser[0] set means a task arrives
// at the start of the tick, with slot, burst and priority in s_tdata. The
// table lives in a RAM of NUM_SLOTS records; busy bits sit in flip-flops.
// Each tick: accept (arrival written to RAM), one RAM read per slot while the
// previous read is compared (smallest priority, then oldest, then lowest
// slot), then the compare of the last entry, the write of the chosen record
// back with one unit less, and the forming of the waiting time with the load
// of the output register. Input is taken one tick at a time; every input beat
// gives exactly one result beat on m_*.
// The result sits in an output register: the next tick is accepted and worked
// on while it waits; only the load of the next result stalls on m_tready.
// Reset clears busy bits, time counter and sequencer; RAM contents are not
// cleared and need no clearing pass, as only busy entries are ever compared.
// Depends on pps_pkg and pps_ram.
`timescale 1ns / 1ps

module preemptive_priority_scheduler #(
    parameter int NUM_SLOTS = pps_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: task_slot[3:0], burst_len[19:4], task_priority[27:20], zero[31:28]
    input  logic [pps_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: opcode[0]
    input  logic [pps_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: running_slot[3:0], turnaround[35:4], waiting[67:36], zero[71:68]
    output logic [pps_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: running_valid[0], done_valid[1], arrive_rejected[2]
    output logic [pps_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    import pps_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    // Input fields
    logic [SLOT_FIELD_W-1:0] in_slot;
    logic [BURST_W-1:0]      in_burst;
    logic [PRIO_W-1:0]       in_prio;
    logic                    in_op;

    assign in_slot  = s_tdata[3:0];
    assign in_burst = s_tdata[19:4];
    assign in_prio  = s_tdata[27:20];
    assign in_op    = s_tuser[0];

    // State
    sched_state_t state_reg, state_next;

    logic [NUM_SLOTS-1:0] busy_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [SLOT_W-1:0]    rd_idx_reg;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic                 cmp_valid_reg;
    logic                 rej_reg;

    // Best candidate so far
    logic                 best_valid_reg;
    logic [SLOT_W-1:0]    best_slot_reg;
    task_rec_t            best_rec_reg;
    logic [TIME_W-1:0]    best_age_reg;

    // Update results
    logic                 done_reg;
    logic [TIME_W-1:0]    tat_reg;

    // Output register
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;
    logic [M_TDATA_W-1:0]   out_data;

    // RAM ports
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    task_rec_t         ram_wdata;
    task_rec_t         ram_rdata;

    // Control
    logic              accept;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic              arrive_ok;
    logic              out_free;
    logic              load_out;

    // Compare path
    logic [TIME_W-1:0] cand_age;
    logic              take;

    // Update path
    logic [BURST_W-1:0] rem_dec;
    logic [TIME_W-1:0]  wait_val;

    pps_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Arrival checks
    assign slot_ok   = ({{(TIME_W-SLOT_FIELD_W){1'b0}}, in_slot} < TIME_W'(NUM_SLOTS));
    assign slot_idx  = SLOT_W'(in_slot);
    assign arrive_ok = (in_op == OP_ARRIVE) && slot_ok && (in_burst != '0)
                       && !busy_reg[slot_idx];

    // Candidate compare against the best so far
    assign cand_age = time_reg - ram_rdata.arrival;
    assign take = cmp_valid_reg && busy_reg[cmp_idx_reg] &&
                  (!best_valid_reg ||
                   (ram_rdata.priority_val < best_rec_reg.priority_val) ||
                   ((ram_rdata.priority_val == best_rec_reg.priority_val) &&
                    (cand_age > best_age_reg)));

    assign rem_dec  = best_rec_reg.remaining - BURST_W'(1);
    assign wait_val = tat_reg - {{(TIME_W-BURST_W){1'b0}}, best_rec_reg.burst};

    assign out_free = !m_tvalid_reg || m_tready;

    // Result data: slot when a task ran, times only when it finished
    always_comb
    begin
        out_data = '0;
        if (best_valid_reg)
        begin
            out_data[3:0] = SLOT_FIELD_W'(best_slot_reg);
        end
        if (best_valid_reg && done_reg)
        begin
            out_data[35:4]  = tat_reg;
            out_data[67:36] = wait_val;
        end
    end

    // Next state and control
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = best_slot_reg;
        ram_wdata  = best_rec_reg;
        case (state_reg)
            ST_IDLE:
            begin
                accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                    if (arrive_ok)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_idx;
                        ram_wdata = '{remaining:    in_burst,
                                      priority_val: in_prio,
                                      burst:        in_burst,
                                      arrival:      time_reg};
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
                if (best_valid_reg)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.remaining = rem_dec;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers: busy bits, time, scan counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            time_reg       <= '0;
            rd_idx_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= (state_reg == ST_SCAN);
            if (accept)
            begin
                rd_idx_reg     <= '0;
                best_valid_reg <= 1'b0;
                if (arrive_ok)
                begin
                    busy_reg[slot_idx] <= 1'b1;
                end
            end
            if (state_reg == ST_SCAN)
            begin
                rd_idx_reg <= rd_idx_reg + SLOT_W'(1);
            end
            if (take)
            begin
                best_valid_reg <= 1'b1;
            end
            if (state_reg == ST_UPDATE)
            begin
                time_reg <= time_reg + TIME_W'(1);
                if (best_valid_reg && (rem_dec == '0))
                begin
                    busy_reg[best_slot_reg] <= 1'b0;
                end
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_idx_reg;
        if (accept)
        begin
            rej_reg <= (in_op == OP_ARRIVE) && !arrive_ok;
        end
        if (take)
        begin
            best_slot_reg <= cmp_idx_reg;
            best_rec_reg  <= ram_rdata;
            best_age_reg  <= cand_age;
        end
        if (state_reg == ST_UPDATE)
        begin
            done_reg <= best_valid_reg && (rem_dec == '0);
            tat_reg  <= best_age_reg + TIME_W'(1);
        end
        if (load_out)
        begin
            m_tuser_reg <= {rej_reg, done_reg && best_valid_reg, best_valid_reg};
            m_tdata_reg <= out_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== design/pps_checker.sv =====
// Port-level checks for the preemptive priority scheduler, bound to the top level.
// Depends on pps_pkg and preemptive_priority_scheduler.
`timescale 1ns / 1ps

module pps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pps_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [pps_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    import pps_pkg::*;

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A finished task must be the one that ran
    a_done_runs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("done without a running task");

    // Times are zero unless a task finished
    a_times_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[67:4] == '0))
        else $error("times reported without completion");

    // One tick at a time: no beat taken right after an accepted one
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
